// File: hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by spq_cell and sorted_priority_queue.
`timescale 1ns / 1ps

package spq_pkg;

  // Command codes carried in the request
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Width of the count field in a result
  localparam int unsigned COUNT_W = 5;

  // One request: command and value to insert
  typedef struct packed {
    logic               cmd;
    logic signed [31:0] value;
  } req_t;

  // One result: queue state after the request
  typedef struct packed {
    logic signed [31:0]  front_value;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
    logic                is_full;
    logic                error;
  } res_t;

  // Per-cycle operation broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/spq_cell.sv
// One storage cell of the sorted chain: holds a single entry.
// Depends on spq_pkg for the control struct.
`timescale 1ns / 1ps

module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic signed [31:0] value,     // broadcast insert value
  input  logic               occ,       // this cell holds a live entry
  input  logic signed [31:0] left_val,  // entry of the neighbour nearer the front
  input  logic               left_ge,   // neighbour nearer the front is displaced
  input  logic signed [31:0] right_val, // entry of the neighbour nearer the back
  output logic signed [31:0] val,
  output logic signed [31:0] val_next,
  output logic               ge
);
  import spq_pkg::*;

  // An empty cell or an entry no larger than the new value gets displaced by it
  assign ge = !occ || (value >= val);

  // Insert: keep, take the new value, or take the left neighbour's entry.
  // Remove: everything moves one place towards the front.
  always_comb begin
    val_next = val;
    if (ctrl.ins) begin
      if (ge) begin
        val_next = left_ge ? left_val : value;
      end
    end else if (ctrl.rem) begin
      val_next = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// File: hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell chain, count and result register.
// Depends on spq_pkg and spq_cell.
`timescale 1ns / 1ps

// Usage
//   Request channel (req_valid / req_stall / req): each request inserts
//   req.value in sorted position (largest first, newest first among equals)
//   or removes the front entry. Result channel (res_valid / res_stall / res):
//   one result per request, giving the front value (0 when empty), the
//   count (low 5 bits), the empty and full flags and an error flag for an
//   insert into a full queue or a remove from an empty one.
// Result timing: the result is registered and appears in the cycle after the
//   request is taken.
// Throughput: one request per cycle while no result is stalled. Every cell
//   compares its entry with the broadcast value and shifts with its
//   neighbours in the same cycle.
// Stall: while a result waits with res_stall high, req_stall is raised and
//   the result is held unchanged; requests resume once it is taken.
// Reset: rst empties the queue (count to zero) and clears res_valid; cell
//   contents are not cleared, the count marks which cells are live.
module sorted_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  spq_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output spq_pkg::res_t res
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic               accept;
  logic               is_full_now;
  logic               is_empty_now;
  logic               err;
  cell_ctrl_t         ctrl;
  logic signed [31:0] vals      [DEPTH];
  logic signed [31:0] vals_next [DEPTH];
  logic [DEPTH-1:0]   ge;
  logic [DEPTH-1:0]   occ;
  logic [CW+COUNT_W-1:0] count_ext;

  // Handshake: hold off while an undelivered result is stalled
  assign req_stall = res_valid && res_stall;
  assign accept    = req_valid && !req_stall;

  assign is_full_now  = (count == DEPTH_C);
  assign is_empty_now = (count == '0);

  // Operation for the chain this cycle
  always_comb begin
    ctrl.ins = accept && (req.cmd == CMD_INSERT) && !is_full_now;
    ctrl.rem = accept && (req.cmd == CMD_REMOVE) && !is_empty_now;
    err      = (req.cmd == CMD_INSERT) ? is_full_now : is_empty_now;
  end

  // Entry count
  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CW'(1);
    end else if (ctrl.rem) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Chain of cells, front at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] lv;
    logic               lg;
    logic signed [31:0] rv;

    assign occ[i] = (CW'(i) < count);

    if (i == 0) begin : g_front
      assign lv = req.value;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = vals[i-1];
      assign lg = ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign rv = vals[i];
    end else begin : g_inner
      assign rv = vals[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .value     (req.value),
      .occ       (occ[i]),
      .left_val  (lv),
      .left_ge   (lg),
      .right_val (rv),
      .val       (vals[i]),
      .val_next  (vals_next[i]),
      .ge        (ge[i])
    );
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_next};

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.front_value <= (count_next == '0) ? 32'sd0 : vals_next[0];
      res.count       <= count_ext[COUNT_W-1:0];
      res.is_empty    <= (count_next == '0);
      res.is_full     <= (count_next == DEPTH_C);
      res.error       <= err;
    end
  end

  // Checks
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count above depth");

  a_err_holds_count : assert property (@(posedge clk) disable iff (rst)
    (accept && err) |=> $stable(count))
    else $error("count changed on a rejected request");

  a_ins_counts : assert property (@(posedge clk) disable iff (rst)
    (accept && req.cmd == CMD_INSERT && !is_full_now) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not add an entry");

  a_empty_front : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.is_empty) |-> (res.front_value == 32'sd0 && !res.is_full))
    else $error("empty result with non-zero front or full flag");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res)))
    else $error("stalled result changed");

endmodule

// File: tb/sorted_priority_queue_test.sv
// Self-checking testbench for sorted_priority_queue: directed and random requests,
// with a shadow model of the sorted entries predicting every result.
// Depends on spq_pkg and the sorted_priority_queue RTL.
`timescale 1ns / 1ps

module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int unsigned QUEUE_DEPTH     = 16;
  localparam int unsigned ITEMS_PER_PHASE = 510;
  localparam int unsigned CYCLE_LIMIT     = 400000;

  // Shadow copy of the queue; predicts each result and checks the DUT output
  class spq_checker #(int unsigned DEPTH = 16);
    logic signed [31:0] shadow [DEPTH];
    int unsigned        held;
    res_t               awaited [$];
    int unsigned        failures;
    int unsigned        n_insert, n_remove, n_dropped, n_underflow, n_checked, peak;

    function new();
      held = 0;
      failures = 0;
      n_insert = 0;
      n_remove = 0;
      n_dropped = 0;
      n_underflow = 0;
      n_checked = 0;
      peak = 0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // Apply an accepted request to the shadow and queue up the result it should give
    function void note_request(req_t r);
      res_t               want;
      logic               err;
      logic signed [31:0] v;
      int                 k;
      err = 1'b0;
      v = r.value;
      if (r.cmd == CMD_INSERT) begin
        n_insert++;
        if (held >= DEPTH) begin
          err = 1'b1;
          n_dropped++;
        end else begin
          // walk up from the tail past every entry <= v, so the newest equal goes first
          k = held;
          while (k > 0 && shadow[k-1] <= v) begin
            shadow[k] = shadow[k-1];
            k--;
          end
          shadow[k] = v;
          held++;
        end
      end else begin
        n_remove++;
        if (held == 0) begin
          err = 1'b1;
          n_underflow++;
        end else begin
          for (k = 1; k < held; k++) shadow[k-1] = shadow[k];
          held--;
        end
      end
      if (held > peak) peak = held;
      want.front_value = (held != 0) ? shadow[0] : '0;
      want.count       = held[COUNT_W-1:0];
      want.is_empty    = (held == 0);
      want.is_full     = (held >= DEPTH);
      want.error       = err;
      awaited = {awaited, want};
    endfunction

    function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
      failures++;
      $display("%0t: %s mismatch, expected 'h%08h, actual 'h%08h", $time, field, exp_v, act_v);
    endfunction

    // Compare an accepted result with the oldest prediction
    function void check_result(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        failures++;
        $display("%0t: result with no request outstanding, front 'h%08h count %0d",
                 $time, got.front_value, got.count);
        return;
      end
      want = awaited.pop_front();
      n_checked++;
      if (got.front_value !== want.front_value)
        report("front_value", want.front_value, got.front_value);
      if (got.count !== want.count) report("count", 32'(want.count), 32'(got.count));
      if (got.is_empty !== want.is_empty)
        report("is_empty", 32'(want.is_empty), 32'(got.is_empty));
      if (got.is_full !== want.is_full) report("is_full", 32'(want.is_full), 32'(got.is_full));
      if (got.error !== want.error) report("error", 32'(want.error), 32'(got.error));
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  req_t req       = '0;
  logic res_stall = 1'b0;
  logic req_stall;
  logic res_valid;
  res_t res;

  int unsigned send_idle_pct = 0;
  int unsigned res_stall_pct = 0;
  int unsigned cycles        = 0;

  spq_checker #(QUEUE_DEPTH) chk;

  sorted_priority_queue #(.DEPTH(QUEUE_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycles, chk.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Random back-pressure on the result side
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(99) < res_stall_pct);
    end
  end

  // Handshake monitor: values read here are the ones the DUT sampled at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) chk.check_result(res);
      if (req_valid && !req_stall) chk.note_request(req);
    end
  end

  // Offer one request, with random idle cycles ahead of it, and wait until it is taken
  task automatic send_request(input logic cmd, input logic signed [31:0] v);
    req_t r;
    r.cmd = cmd;
    r.value = v;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Hold off the sender until every outstanding result has come back;
  // it first waits on the clock so the monitor has noted the last request taken
  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (chk.pending() != 0) @(posedge clk);
  endtask

  // Extremes, heavy duplicates and fully random words
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4, 5, 6: return $signed(32'($urandom_range(15))) - 32'sd8;
      default: return $signed($urandom());
    endcase
  endfunction

  initial begin
    int unsigned ins_bias;
    logic        cmd;
    chk = new();
    send_idle_pct = 19;
    res_stall_pct = 84;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: remove when empty, extremes and equal values, fill to full, drop on full
    send_request(CMD_REMOVE, $signed($urandom()));
    send_request(CMD_INSERT, 32'sh7FFF_FFFF);
    send_request(CMD_INSERT, 32'sh8000_0000);
    send_request(CMD_INSERT, 32'sd0);
    send_request(CMD_INSERT, -32'sd1);
    send_request(CMD_INSERT, 32'sd0);
    send_request(CMD_INSERT, -32'sd1);
    send_request(CMD_INSERT, 32'sh7FFF_FFFF);
    send_request(CMD_INSERT, 32'sh8000_0000);
    repeat (8) send_request(CMD_INSERT, pick_value());
    send_request(CMD_INSERT, 32'sd5);
    repeat (4) send_request(CMD_REMOVE, $signed($urandom()));

    // Random phases: idling on each side in turn, then none
    for (int phase = 0; phase < 3; phase++) begin
      drain_results();
      case (phase)
        0: begin
          send_idle_pct = 19;
          res_stall_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          res_stall_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          res_stall_pct = 0;
        end
      endcase
      ins_bias = 50;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // swing between filling and emptying so both ends of the queue are reached
        if (i % 40 == 0) begin
          case ($urandom_range(2))
            0:       ins_bias = 15;
            1:       ins_bias = 50;
            default: ins_bias = 85;
          endcase
        end
        cmd = ($urandom_range(99) < ins_bias) ? CMD_INSERT : CMD_REMOVE;
        send_request(cmd, pick_value());
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("Checked %0d results: %0d inserts (%0d dropped as full), %0d removes (%0d on empty)",
             chk.n_checked, chk.n_insert, chk.n_dropped, chk.n_remove, chk.n_underflow);
    $display("Deepest fill %0d of %0d entries, %0d mismatches",
             chk.peak, QUEUE_DEPTH, chk.failures);
    if (chk.failures == 0 && chk.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
